>>> rtl/diag_bus_responder_core_assert.svh
// assertion macros used by the checker of the diagnostic bus responder
`ifndef DIAG_BUS_RESPONDER_CORE_ASSERT_SVH
`define DIAG_BUS_RESPONDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DBR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dbr check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DBR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dbr check failed");

`endif

>>> rtl/dbr_pkg.sv
`default_nettype none

package dbr_pkg;

  localparam int unsigned RamDepth  = 256;
  localparam int unsigned RamAw     = $clog2(RamDepth);
  localparam int unsigned DataW     = 8;
  localparam int unsigned BoardW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxUpload = 62;
  localparam int unsigned CntW      = $clog2(MaxUpload + 1);

  localparam logic [DataW-1:0] UpHeader     = 8'h02;
  localparam logic [RamAw-1:0] UpHeaderAddr = 8'h11;
  localparam logic [RamAw-1:0] DnBase       = 8'h10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOARD_ADDR = 2'd0,
    CFG_RESPONSE   = 2'd1,
    CFG_RESET_CODE = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_STATUS   = 4'h0,
    CMD_UPLOAD   = 4'h2,
    CMD_RESET    = 4'h8,
    CMD_DOWNLOAD = 4'ha
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_PTR,
    ST_UP_CNT,
    ST_UP_HDR,
    ST_UP_RD,
    ST_UP_DATA,
    ST_UP_SUM,
    ST_DN_CNT,
    ST_DN_DATA,
    ST_DN_CSUM,
    ST_DN_ERR,
    ST_STATUS
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OUT_STATUS,
    OUT_HDR,
    OUT_DATA,
    OUT_SUM,
    OUT_ERR
  } out_sel_e;

  typedef struct packed {
    logic     clr_step;
    logic     take_ptr;
    logic     take_ucnt;
    logic     take_dcnt;
    logic     take_ddata;
    logic     set_pending;
    logic     hdr_wr;
    logic     rd_issue;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       addr_match;
    logic [3:0] cmd;
    logic       in_zero;
    logic       rem_one;
    logic       csum_ok;
    logic       cnt_zero;
    logic       cnt_one;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/dbr_if.sv
`default_nettype none

// bus word channel
interface dbr_in_if;
  logic       valid;
  logic       ready;
  logic       marker;
  logic [7:0] bus_byte;

  modport source (output valid, output marker, output bus_byte, input ready);
  modport sink (input valid, input marker, input bus_byte, output ready);
endinterface

// reply byte channel
interface dbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;
  logic       checksum_error;

  modport source (output valid, output tx_byte, output last, output checksum_error,
                  input ready);
  modport sink (input valid, input tx_byte, input last, input checksum_error,
                output ready);
endinterface

`default_nettype wire

>>> rtl/dbr_ram.sv
`default_nettype none

module dbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/dbr_ctrl.sv
`default_nettype none

module dbr_ctrl
  import dbr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire dp_status_t status_i,
  output logic            in_ready_o,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_sel = OUT_STATUS;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && status_i.addr_match) begin
          if (status_i.cmd == CMD_STATUS) begin
            state_d = ST_STATUS;
          end else if (status_i.cmd == CMD_UPLOAD) begin
            state_d = ST_UP_PTR;
          end else if (status_i.cmd == CMD_RESET) begin
            cmd_o.set_pending = 1'b1;
          end else if (status_i.cmd == CMD_DOWNLOAD) begin
            state_d = ST_DN_CNT;
          end
        end
      end
      ST_UP_PTR: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_ptr = 1'b1;
          state_d = ST_UP_CNT;
        end
      end
      ST_UP_CNT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_ucnt = 1'b1;
          state_d = ST_UP_HDR;
        end
      end
      ST_UP_HDR: begin
        cmd_o.hdr_wr  = 1'b1;
        cmd_o.out_sel = OUT_HDR;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = status_i.cnt_zero ? ST_UP_SUM : ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = ST_UP_DATA;
      end
      ST_UP_DATA: begin
        cmd_o.out_sel = OUT_DATA;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = status_i.cnt_one ? ST_UP_SUM : ST_UP_RD;
        end
      end
      ST_UP_SUM: begin
        cmd_o.out_sel = OUT_SUM;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DN_CNT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_dcnt = 1'b1;
          state_d = status_i.in_zero ? ST_DN_CSUM : ST_DN_DATA;
        end
      end
      ST_DN_DATA: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_ddata = 1'b1;
          state_d = status_i.rem_one ? ST_DN_CSUM : ST_DN_DATA;
        end
      end
      ST_DN_CSUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = status_i.csum_ok ? ST_IDLE : ST_DN_ERR;
        end
      end
      ST_DN_ERR: begin
        cmd_o.out_sel = OUT_ERR;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_STATUS: begin
        cmd_o.out_sel = OUT_STATUS;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dbr_dp.sv
`default_nettype none

module dbr_dp
  import dbr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_data_i,
  input  wire logic               in_marker_i,
  input  wire logic [DataW-1:0]   in_byte_i,
  input  wire logic               out_ready_i,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  output logic      [DataW-1:0]   out_tx_byte_o,
  output logic                    out_last_o,
  output logic                    out_err_o
);

  logic [BoardW-1:0] board_q;
  logic [DataW-1:0]  resp_q, rst_code_q, tmo_q;
  logic [DataW-1:0]  pending_q, sum_q, rem_q;
  logic [RamAw-1:0]  ptr_q, clr_q;
  logic [CntW-1:0]   cnt_q, cnt_sat;
  logic              out_valid_q;
  logic [DataW-1:0]  tx_q, tx_d;
  logic              last_q, last_d, err_q, err_d;

  logic              ram_we;
  logic [RamAw-1:0]  ram_waddr;
  logic [DataW-1:0]  ram_wdata, ram_rdata, status_byte;

  // scratch memory, written by clearing, upload header and download data
  assign ram_we    = cmd_i.clr_step | cmd_i.hdr_wr | cmd_i.take_ddata;
  assign ram_waddr = cmd_i.clr_step ? clr_q : (cmd_i.hdr_wr ? UpHeaderAddr : ptr_q);
  assign ram_wdata = cmd_i.clr_step ? '0 : (cmd_i.hdr_wr ? UpHeader : in_byte_i);

  dbr_ram #(
    .Width (DataW),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign cnt_sat = (in_byte_i > DataW'(MaxUpload)) ? CntW'(MaxUpload)
                                                   : in_byte_i[CntW-1:0];

  assign status_byte = ((pending_q != '0) && (resp_q != tmo_q)) ? pending_q : resp_q;

  always_comb begin
    tx_d   = status_byte;
    last_d = 1'b1;
    err_d  = 1'b0;
    case (cmd_i.out_sel)
      OUT_STATUS: begin
        tx_d = status_byte;
      end
      OUT_HDR: begin
        tx_d   = UpHeader;
        last_d = 1'b0;
      end
      OUT_DATA: begin
        tx_d   = ram_rdata;
        last_d = 1'b0;
      end
      OUT_SUM: begin
        tx_d = sum_q;
      end
      OUT_ERR: begin
        tx_d  = '0;
        err_d = 1'b1;
      end
      default: begin
        tx_d = status_byte;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q     <= '0;
      resp_q      <= '0;
      rst_code_q  <= 8'h01;
      tmo_q       <= 8'h02;
      pending_q   <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      ptr_q       <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOARD_ADDR: board_q    <= cfg_data_i[BoardW-1:0];
          CFG_RESPONSE:   resp_q     <= cfg_data_i;
          CFG_RESET_CODE: rst_code_q <= cfg_data_i;
          CFG_TIMEOUT:    tmo_q      <= cfg_data_i;
          default:        board_q    <= board_q;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.set_pending) begin
        pending_q <= rst_code_q;
      end else if (cmd_i.out_load && cmd_i.out_sel == OUT_STATUS) begin
        pending_q <= '0;
      end
      if (cmd_i.take_ptr) begin
        ptr_q <= in_byte_i;
      end else if (cmd_i.take_dcnt) begin
        ptr_q <= DnBase;
      end else if (cmd_i.take_ddata || (cmd_i.out_load && cmd_i.out_sel == OUT_DATA)) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.take_dcnt) begin
        rem_q <= in_byte_i;
      end else if (cmd_i.take_ddata) begin
        rem_q <= rem_q - 1'b1;
      end
      if (cmd_i.take_dcnt) begin
        sum_q <= in_byte_i;
      end else if (cmd_i.take_ddata) begin
        sum_q <= sum_q + in_byte_i;
      end else if (cmd_i.out_load && cmd_i.out_sel == OUT_HDR) begin
        sum_q <= UpHeader;
      end else if (cmd_i.out_load && cmd_i.out_sel == OUT_DATA) begin
        sum_q <= sum_q + ram_rdata;
      end
      if (cmd_i.take_ucnt) begin
        cnt_q <= cnt_sat;
      end else if (cmd_i.out_load && cmd_i.out_sel == OUT_DATA) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tx_q   <= tx_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign status_o.clr_done   = (clr_q == RamAw'(RamDepth - 1));
  assign status_o.addr_match = in_marker_i && (in_byte_i[BoardW-1:0] == board_q);
  assign status_o.cmd        = in_byte_i[DataW-1:DataW-4];
  assign status_o.in_zero    = (in_byte_i == '0);
  assign status_o.rem_one    = (rem_q == 8'd1);
  assign status_o.csum_ok    = (in_byte_i == sum_q);
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.cnt_one    = (cnt_q == CntW'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_tx_byte_o = tx_q;
  assign out_last_o    = last_q;
  assign out_err_o     = err_q;

endmodule

`default_nettype wire

>>> rtl/diag_bus_responder_core.sv
// a status or checksum error reply passes its reply state, then the output register,
// after its word is accepted; one bus word per cycle is taken in waiting phases;
// an upload of n bytes streams n + 2 beats, a read state and a data state per data
// byte, set by the registered ram read port
// reset: asynchronous, active low; then a clearing pass over every scratch ram
// address holds ready low (configuration writes are still taken)
`default_nettype none

module diag_bus_responder_core
  import dbr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_data_i,
  // bus words in, reply beats out
  dbr_in_if.sink                  in_ch,
  dbr_out_if.source               out_ch
);

  // command and status between controller and datapath
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  // controller: walks the command phases, sequences the upload stream and
  // the power-up clearing pass
  dbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .status_i   (dp_status),
    .in_ready_o (in_ready),
    .cmd_o      (ctrl_cmd)
  );

  // datapath: configuration, pointer, counters, running sum, scratch ram and
  // the output register that decouples the reply side
  dbr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_marker_i   (in_ch.marker),
    .in_byte_i     (in_ch.bus_byte),
    .out_ready_i   (out_ch.ready),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .out_valid_o   (out_ch.valid),
    .out_tx_byte_o (out_ch.tx_byte),
    .out_last_o    (out_ch.last),
    .out_err_o     (out_ch.checksum_error)
  );

  // words are taken in any waiting phase, even while a reply beat is unclaimed
  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

>>> rtl/dbr_checker.sv
`default_nettype none
`include "diag_bus_responder_core_assert.svh"

module dbr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_tx_byte_i,
  input wire logic       out_last_i,
  input wire logic       out_err_i
);

  // a stalled beat stays offered
  `DBR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // and keeps its byte
  `DBR_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_tx_byte_i))
  // checksum error beat is a lone zero byte closing its run
  `DBR_ASSERT_IMP(a_err_form, out_valid_i && out_err_i,
                  out_last_i && (out_tx_byte_i == 8'h00))
  // mid-upload no bus word is taken
  `DBR_ASSERT_IMP(a_upload_blocks, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind diag_bus_responder_core dbr_checker u_dbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_tx_byte_i (out_ch.tx_byte),
  .out_last_i    (out_ch.last),
  .out_err_i     (out_ch.checksum_error)
);

`default_nettype wire

>>> dv/tb_diag_bus_responder_core.sv
`timescale 1ns / 1ps

module tb_diag_bus_responder_core;
  import dbr_pkg::*;

  // run shape
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WordsPerPhase = 28;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned NoisePhase    = 2;
  localparam int unsigned WrapPhase     = 3;
  localparam int unsigned NoiseWords    = 12;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic [DataW-1:0] tx_byte;
    logic             last;
    logic             checksum_error;
  } reply_beat_t;

  // one directed bus word, with an optional typed-in reply beat
  typedef struct {
    logic             marker;
    logic [DataW-1:0] bus_byte;
    bit               typed;
    reply_beat_t      beat;
    bit               hold;
  } dir_row_t;

  // where the responder stands in a command, as far as the predictor knows
  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_UP_PTR,
    BUS_UP_CNT,
    BUS_DN_CNT,
    BUS_DN_DATA,
    BUS_DN_CSUM
  } bus_phase_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DataW-1:0]   cfg_data;

  dbr_in_if  in_ch ();
  dbr_out_if out_ch ();

  diag_bus_responder_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // predictor copy of registers and state
  logic [BoardW-1:0] m_board;
  logic [DataW-1:0]  m_response;
  logic [DataW-1:0]  m_reset_code;
  logic [DataW-1:0]  m_timeout;
  bus_phase_e        m_phase;
  logic [DataW-1:0]  m_pending;
  logic [RamAw-1:0]  m_ptr;
  logic [DataW-1:0]  m_left;
  logic [DataW-1:0]  m_sum;
  logic [DataW-1:0]  m_ram [RamDepth];

  reply_beat_t reply_q [$];     // reply beats still owed by the block
  reply_beat_t step_beats [$];  // beats caused by the latest word
  bit          word_taken;      // latest word did something
  int unsigned taken_cnt;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  bit          steady;          // no idling on either side

  // directed words: reset values, marker and address filtering, every command,
  // upload header overwrite, saturation, address wrap, checksum error
  dir_row_t dir_rows [25] = '{
    '{1'b1, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},  // status after reset
    '{1'b1, 8'h80, 1'b0, '0, 1'b0},                     // reset reply pending
    '{1'b1, 8'h00, 1'b1, '{8'h01, 1'b1, 1'b0}, 1'b0},  // pending reset code
    '{1'b1, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},  // pending cleared
    '{1'b0, 8'h00, 1'b0, '0, 1'b0},                     // no marker in idle
    '{1'b1, 8'h01, 1'b0, '0, 1'b0},                     // foreign address
    '{1'b1, 8'h40, 1'b0, '0, 1'b0},                     // unknown command
    '{1'b1, 8'ha0, 1'b0, '0, 1'b0},                     // download of three
    '{1'b0, 8'h03, 1'b0, '0, 1'b0},
    '{1'b0, 8'hff, 1'b0, '0, 1'b0},
    '{1'b1, 8'h00, 1'b0, '0, 1'b0},                     // data with marker set
    '{1'b0, 8'h7f, 1'b0, '0, 1'b0},
    '{1'b1, 8'h81, 1'b0, '0, 1'b0},                     // matching checksum
    '{1'b1, 8'h20, 1'b0, '0, 1'b0},                     // upload over 0x11
    '{1'b0, 8'h10, 1'b0, '0, 1'b0},
    '{1'b0, 8'h04, 1'b0, '0, 1'b1},
    '{1'b1, 8'ha0, 1'b0, '0, 1'b0},                     // empty download
    '{1'b0, 8'h00, 1'b0, '0, 1'b0},
    '{1'b0, 8'h55, 1'b1, '{8'h00, 1'b1, 1'b1}, 1'b0},  // checksum mismatch
    '{1'b1, 8'h20, 1'b0, '0, 1'b0},                     // saturated, wrapping
    '{1'b0, 8'hf8, 1'b0, '0, 1'b0},
    '{1'b0, 8'hff, 1'b0, '0, 1'b1},
    '{1'b1, 8'h20, 1'b0, '0, 1'b0},                     // upload of nothing
    '{1'b1, 8'h00, 1'b0, '0, 1'b0},
    '{1'b0, 8'h00, 1'b0, '0, 1'b0}
  };

  function automatic reply_beat_t mk_beat(input logic [DataW-1:0] b, input logic last,
                                          input logic err);
    reply_beat_t beat;
    beat.tx_byte        = b;
    beat.last           = last;
    beat.checksum_error = err;
    return beat;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // words after a command are taken whatever their marker
  function automatic logic follow_marker();
    return $urandom_range(0, 3) == 0;
  endfunction

  // advance the predictor by one bus word, leaving its reply beats in step_beats
  task automatic predict_reply(input logic marker, input logic [DataW-1:0] word);
    int unsigned      cnt;
    logic [DataW-1:0] v;
    step_beats.delete();
    word_taken = 1'b1;
    case (m_phase)
      BUS_UP_PTR: begin
        m_ptr   = word;
        m_phase = BUS_UP_CNT;
      end
      BUS_UP_CNT: begin
        cnt = (word > MaxUpload) ? MaxUpload : word;
        // header byte lands in ram before the read-out
        m_ram[UpHeaderAddr] = UpHeader;
        m_sum = UpHeader;
        step_beats.push_back(mk_beat(UpHeader, 1'b0, 1'b0));
        repeat (cnt) begin
          v     = m_ram[m_ptr];
          m_ptr = m_ptr + 1'b1;
          m_sum = m_sum + v;
          step_beats.push_back(mk_beat(v, 1'b0, 1'b0));
        end
        step_beats.push_back(mk_beat(m_sum, 1'b1, 1'b0));
        m_left  = '0;
        m_phase = BUS_IDLE;
      end
      BUS_DN_CNT: begin
        m_ptr   = DnBase;
        m_left  = word;
        m_sum   = word;
        m_phase = (word == '0) ? BUS_DN_CSUM : BUS_DN_DATA;
      end
      BUS_DN_DATA: begin
        m_ram[m_ptr] = word;
        m_ptr  = m_ptr + 1'b1;
        m_sum  = m_sum + word;
        m_left = m_left - 1'b1;
        if (m_left == '0) m_phase = BUS_DN_CSUM;
      end
      BUS_DN_CSUM: begin
        if (word != m_sum) step_beats.push_back(mk_beat('0, 1'b1, 1'b1));
        m_phase = BUS_IDLE;
      end
      default: begin
        m_phase    = BUS_IDLE;
        word_taken = 1'b0;
        if (marker && word[BoardW-1:0] == m_board) begin
          word_taken = 1'b1;
          case (word[7:4])
            CMD_STATUS: begin
              // a pending reply is hidden while response equals timeout
              if (m_pending != '0 && m_response != m_timeout) begin
                step_beats.push_back(mk_beat(m_pending, 1'b1, 1'b0));
              end else begin
                step_beats.push_back(mk_beat(m_response, 1'b1, 1'b0));
              end
              m_pending = '0;
            end
            CMD_UPLOAD:   m_phase = BUS_UP_PTR;
            CMD_RESET:    m_pending = m_reset_code;
            CMD_DOWNLOAD: m_phase = BUS_DN_CNT;
            default:      word_taken = 1'b0;
          endcase
        end
      end
    endcase
  endtask

  // present one word after a random gap and hold it until taken; valid stays high after
  task automatic send_word(input logic marker, input logic [DataW-1:0] word,
                           input bit typed = 1'b0, input reply_beat_t typed_beat = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.marker   <= marker;
    in_ch.bus_byte <= word;
    do @(posedge clk); while (!in_ch.ready);
    predict_reply(marker, word);
    if (word_taken) taken_cnt++;
    if (typed) begin
      reply_q.push_back(typed_beat);
    end else begin
      foreach (step_beats[k]) reply_q.push_back(step_beats[k]);
    end
  endtask

  // stop sending until every owed beat is back, then let the block settle
  task automatic wait_for_replies(input int unsigned settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOARD_ADDR: m_board      = data[BoardW-1:0];
      CFG_RESPONSE:   m_response   = data;
      CFG_RESET_CODE: m_reset_code = data;
      default:        m_timeout    = data;
    endcase
  endtask

  // download of cnt bytes; only sent bytes go out, the checksum only when all did
  task automatic send_download(input int unsigned cnt, input int unsigned sent,
                               input bit corrupt);
    logic [DataW-1:0] sum;
    logic [DataW-1:0] d;
    send_word(1'b1, {CMD_DOWNLOAD, m_board[3:0]});
    sum = 8'(cnt);
    send_word(follow_marker(), 8'(cnt));
    for (int unsigned k = 0; k < sent; k++) begin
      d   = 8'($urandom);
      sum = sum + d;
      send_word(follow_marker(), d);
    end
    if (sent == cnt) begin
      send_word(follow_marker(), corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  // one command sequence, mostly well formed; truncated downloads swallow what follows
  task automatic send_random_sequence();
    int unsigned      pick;
    int unsigned      cnt;
    logic [3:0]       ba;
    logic [DataW-1:0] ptr;
    ba     = m_board[3:0];
    steady = ($urandom_range(0, 5) == 0);
    pick   = $urandom_range(0, 99);
    if (pick < 14) begin
      send_word(1'b1, {CMD_STATUS, ba});
    end else if (pick < 24) begin
      send_word(1'b1, {CMD_RESET, ba});
    end else if (pick < 50) begin
      send_word(1'b1, {CMD_UPLOAD, ba});
      // pointer mostly near the download area and the header byte
      ptr  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'h0c, 8'h20)) : 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) cnt = $urandom_range(0, 8);
      else if (pick < 9) cnt = $urandom_range(9, MaxUpload);
      else cnt = $urandom_range(MaxUpload + 1, 255);
      send_word(follow_marker(), ptr);
      send_word(follow_marker(), 8'(cnt));
      if ($urandom_range(0, 7) == 0) wait_for_replies(0);
    end else if (pick < 76) begin
      cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      send_download(cnt, cnt, $urandom_range(0, 4) == 0);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) send_word(1'($urandom), 8'($urandom));
    end else begin
      cnt = $urandom_range(3, 10);
      send_download(cnt, $urandom_range(0, cnt - 1), 1'b0);
    end
  endtask

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    int unsigned g;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        stall_left = g - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // reply beat checker, oldest expectation first
  always @(posedge clk) begin
    reply_beat_t want;
    reply_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk_beat(out_ch.tx_byte, out_ch.last, out_ch.checksum_error);
      if (reply_q.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("stray beat: tx %02h last %0b err %0b", got.tx_byte, got.last,
                   got.checksum_error);
        end
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          if (mismatches < MaxReports) begin
            $display("beat mismatch: expected tx %02h last %0b err %0b, got tx %02h last %0b err %0b",
                     want.tx_byte, want.last, want.checksum_error,
                     got.tx_byte, got.last, got.checksum_error);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [BoardW-1:0] board;
    logic [DataW-1:0]  resp;
    logic [DataW-1:0]  rcode;
    logic [DataW-1:0]  tmo;
    int unsigned       start;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_BOARD_ADDR;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.marker   = 1'b0;
    in_ch.bus_byte = '0;
    out_ch.ready   = 1'b0;
    stall_left     = 0;
    steady         = 1'b0;
    taken_cnt      = 0;
    mismatches     = 0;
    cycle_cnt      = 0;
    // predictor at its reset values
    m_board      = '0;
    m_response   = '0;
    m_reset_code = 8'h01;
    m_timeout    = 8'h02;
    m_phase      = BUS_IDLE;
    m_pending    = '0;
    m_ptr        = '0;
    m_left       = '0;
    m_sum        = '0;
    foreach (m_ram[i]) m_ram[i] = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset configuration, through the ram clearing pass
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].marker, dir_rows[i].bus_byte, dir_rows[i].typed, dir_rows[i].beat);
      if (dir_rows[i].hold) wait_for_replies(0);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_for_replies(SettleCycles);
      case (ph)
        0: begin
          // top of every code, highest address that can carry a command
          board = 5'd15;
          resp  = 8'hff;
          rcode = 8'hff;
          tmo   = 8'h00;
        end
        1: begin
          // response equals timeout, pending replies hidden
          board = 5'd0;
          resp  = 8'h02;
          rcode = 8'h07;
          tmo   = 8'h02;
        end
        NoisePhase: begin
          // bit 4 of the address clashes with every known command
          board = 5'd31;
          resp  = 8'($urandom);
          rcode = 8'($urandom_range(1, 255));
          tmo   = 8'($urandom);
        end
        WrapPhase: begin
          board = 5'($urandom_range(0, 15));
          resp  = 8'($urandom);
          rcode = 8'($urandom_range(1, 255));
          tmo   = ($urandom_range(0, 9) < 3) ? resp : 8'($urandom);
        end
        default: begin
          board = 5'($urandom_range(0, 15));
          resp  = 8'h00;
          rcode = 8'h01;
          tmo   = 8'hff;
        end
      endcase
      // upper data bits on the address write are dropped by the block
      write_reg(CFG_BOARD_ADDR, {3'($urandom), board});
      write_reg(CFG_RESPONSE, resp);
      write_reg(CFG_RESET_CODE, rcode);
      write_reg(CFG_TIMEOUT, tmo);
      steady = 1'b0;
      if (ph == NoisePhase) begin
        repeat (NoiseWords) begin
          if ($urandom_range(0, 1) == 0) send_word(1'b1, {3'($urandom), 5'h1f});
          else send_word(1'($urandom), 8'($urandom));
        end
      end else begin
        start = taken_cnt;
        while (taken_cnt - start < WordsPerPhase) send_random_sequence();
      end
    end

    steady = 1'b0;
    wait_for_replies(SettleCycles * 2);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
